// ----- rtl/gsb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_pkg
// Shared types, constants and saturating helpers of the Goertzel bin engine.
// ----------------------------------------------------------------------------
package gsb_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int REG_INDEX_W      = 8;

  localparam logic [REG_INDEX_W-1:0] REG_TWO_COS_W0   = 8'd0;
  localparam logic [REG_INDEX_W-1:0] REG_COS_W0       = 8'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SIN_W0       = 8'd2;
  localparam logic [REG_INDEX_W-1:0] REG_BLOCK_LENGTH = 8'd3;

  localparam logic signed [31:0] TWO_COS_RESET = 32'sd0;
  localparam logic signed [31:0] COS_RESET     = 32'sd0;
  localparam logic signed [31:0] SIN_RESET     = 32'sd1073741824;
  localparam logic [15:0]        LENGTH_RESET  = 16'd1024;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic        f;
    logic signed [63:0] v;
  } sat_t;

  // one finished window handed from front to back
  typedef struct packed {
    logic signed [63:0] a1;
    logic signed [63:0] a2;
    logic               ovf;
  } entry_t;

  function automatic sat_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [64:0] s;
    sat_t r;
    s = {a[63], a} + {b[63], b};
    r.f = (s[64] != s[63]);
    r.v = r.f ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sat_t sat_sub(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [64:0] s;
    sat_t r;
    s = {a[63], a} - {b[63], b};
    r.f = (s[64] != s[63]);
    r.v = r.f ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  // arctangent of 2^-i in 2^-30 rad, truncated
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gsb_mulq30.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_mulq30
// Q.30 coefficient multiply of a 64-bit value, two 32x32 halves, rounded
// half away from zero and saturated.
// ----------------------------------------------------------------------------
module gsb_mulq30 (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [31:0] c,
  output logic               done,
  output logic signed [63:0] res,
  output logic               ovf
);
  import gsb_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_FIN} mstate_t;

  mstate_t     state;
  logic [63:0] ua;
  logic [31:0] uc;
  logic        neg;
  logic [63:0] plo;
  logic [63:0] phi;
  logic [31:0] mul_a;
  logic [63:0] mprod;
  logic [64:0] round_lo;
  logic [65:0] m;

  assign mul_a    = (state == M_LO) ? ua[31:0] : ua[63:32];
  assign mprod    = mul_a * uc;
  assign round_lo = {1'b0, plo} + 65'd536870912;
  assign m        = {phi, 2'b00} + 66'(round_lo >> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            ua    <= a[63] ? 64'd0 - a : a;
            uc    <= c[31] ? 32'd0 - c : c;
            neg   <= a[63] != c[31];
            state <= M_LO;
          end
        end
        M_LO: begin
          plo   <= mprod;
          state <= M_HI;
        end
        M_HI: begin
          phi   <= mprod;
          state <= M_FIN;
        end
        M_FIN: begin
          if (phi > 64'h2000_0000_0000_0000) begin
            ovf <= 1'b1;
            res <= neg ? S64_MIN : S64_MAX;
          end else if (neg) begin
            ovf <= m > 66'h0_8000_0000_0000_0000;
            res <= (m > 66'h0_8000_0000_0000_0000) ? S64_MIN : 64'd0 - m[63:0];
          end else begin
            ovf <= m > 66'h0_7FFF_FFFF_FFFF_FFFF;
            res <= (m > 66'h0_7FFF_FFFF_FFFF_FFFF) ? S64_MAX : m[63:0];
          end
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gsb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_queue
// Short first-word-fall-through queue of finished windows.
// ----------------------------------------------------------------------------
module gsb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  gsb_pkg::entry_t wr_data,
  output logic            q_full,
  input  logic            rd,
  output gsb_pkg::entry_t rd_data,
  output logic            q_empty
);
  import gsb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = (count == CW'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gsb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_front
// Sample intake and Goertzel recurrence; hands each finished window to the
// queue.
// ----------------------------------------------------------------------------
module gsb_front #(
  parameter int SAMPLE_WIDTH = gsb_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = gsb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  output logic                    full,
  input  logic signed [31:0]      two_cos_w0,
  input  logic [15:0]             block_length,
  output logic                    q_push,
  output gsb_pkg::entry_t         q_data,
  input  logic                    q_full
);
  import gsb_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_ADD, F_SUB, F_PUSH} fstate_t;

  fstate_t                 state;
  logic signed [63:0]      acc_prev;
  logic signed [63:0]      acc_prev2;
  logic signed [63:0]      x_q30;
  logic signed [63:0]      prod;
  logic signed [63:0]      partial;
  logic [COUNT_WIDTH-1:0]  sample_count;
  logic [COUNT_WIDTH-1:0]  n_low;
  logic [COUNT_WIDTH:0]    n_full;
  logic [COUNT_WIDTH:0]    count_inc;
  logic                    overflow_seen;
  logic                    step_ovf;
  logic                    ovf_all;
  logic                    mul_done;
  logic                    mul_ovf;
  logic signed [63:0]      mul_res;
  logic                    accept;
  sat_t                    add_r;
  sat_t                    sub_r;
  entry_t                  pend;

  assign full      = (state != F_IDLE);
  assign accept    = push && !full;
  assign n_low     = COUNT_WIDTH'(block_length);
  assign n_full    = (n_low == '0) ? {1'b1, {COUNT_WIDTH{1'b0}}} : {1'b0, n_low};
  assign count_inc = {1'b0, sample_count} + (COUNT_WIDTH + 1)'(1);
  assign add_r     = sat_add(x_q30, prod);
  assign sub_r     = sat_sub(partial, acc_prev2);
  assign ovf_all   = overflow_seen || step_ovf || sub_r.f;
  assign q_push    = (state == F_PUSH) && !q_full;
  assign q_data    = pend;

  gsb_mulq30 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .a     (acc_prev),
    .c     (two_cos_w0),
    .done  (mul_done),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      acc_prev      <= '0;
      acc_prev2     <= '0;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
      step_ovf      <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            x_q30    <= {{(64 - SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample} <<< 30;
            step_ovf <= 1'b0;
            state    <= F_MUL;
          end
        end
        F_MUL: begin
          if (mul_done) begin
            prod     <= mul_res;
            step_ovf <= mul_ovf;
            state    <= F_ADD;
          end
        end
        F_ADD: begin
          partial  <= add_r.v;
          step_ovf <= step_ovf || add_r.f;
          state    <= F_SUB;
        end
        F_SUB: begin
          acc_prev2 <= acc_prev;
          acc_prev  <= sub_r.v;
          if (count_inc == n_full) begin
            pend.a1  <= sub_r.v;
            pend.a2  <= acc_prev;
            pend.ovf <= ovf_all;
            state    <= F_PUSH;
          end else begin
            sample_count  <= count_inc[COUNT_WIDTH-1:0];
            overflow_seen <= ovf_all;
            state         <= F_IDLE;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            acc_prev      <= '0;
            acc_prev2     <= '0;
            sample_count  <= '0;
            overflow_seen <= 1'b0;
            state         <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gsb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_back
// Window finish: real and imaginary parts, magnitude by square root and
// division, phase by CORDIC vectoring; one result register.
// ----------------------------------------------------------------------------
module gsb_back #(
  parameter int COUNT_WIDTH  = gsb_pkg::COUNT_WIDTH_DEF,
  parameter int CORDIC_STEPS = gsb_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  gsb_pkg::entry_t    q_data,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic signed [31:0] cos_w0,
  input  logic signed [31:0] sin_w0,
  input  logic [15:0]        block_length,
  input  logic               pop,
  output logic               empty,
  output logic signed [63:0] real_part,
  output logic signed [63:0] imag_part,
  output logic [23:0]        magnitude,
  output logic signed [15:0] phase,
  output logic               saturated
);
  import gsb_pkg::*;

  localparam int DIV_W = 44;
  localparam int CCW   = $clog2(CORDIC_STEPS + 1);
  localparam logic signed [39:0] PI_Q30 = 40'sd3373259426;

  typedef enum logic [3:0] {
    B_IDLE, B_COS, B_SIN, B_SQ, B_SQRT, B_DIVLD, B_DIV, B_NORM, B_ROT, B_FIN
  } bstate_t;

  bstate_t                state;
  logic signed [63:0]     a1;
  logic signed [63:0]     a2;
  logic signed [63:0]     re;
  logic signed [63:0]     im;
  logic                   sat_f;
  logic [63:0]            ure;
  logic [63:0]            uim;
  logic                   mul_start;
  logic signed [63:0]     mul_a;
  logic signed [31:0]     mul_c;
  logic                   mul_done;
  logic                   mul_ovf;
  logic signed [63:0]     mul_res;
  sat_t                   re_r;
  logic [3:0]             k;
  logic [63:0]            sq_src;
  logic [31:0]            sq_a;
  logic [31:0]            sq_b;
  logic [63:0]            sq_prod;
  logic [63:0]            prod;
  logic [6:0]             pshift;
  logic                   pvalid;
  logic [127:0]           acc;
  logic [127:0]           acc_next;
  logic [127:0]           val;
  logic [67:0]            rem;
  logic [67:0]            rem_sh;
  logic [67:0]            trial;
  logic                   sq_ge;
  logic [63:0]            root;
  logic [5:0]             scnt;
  logic [COUNT_WIDTH-1:0] n_low;
  logic [COUNT_WIDTH:0]   n_full;
  logic [64:0]            rsum;
  logic [DIV_W-1:0]       dq;
  logic [COUNT_WIDTH+1:0] drem;
  logic [COUNT_WIDTH+1:0] dr2;
  logic                   d_ge;
  logic [5:0]             dcnt;
  logic [63:0]            nx;
  logic [63:0]            ny;
  logic [63:0]            mx;
  logic signed [63:0]     x;
  logic signed [63:0]     y;
  logic signed [39:0]     z;
  logic signed [63:0]     dx;
  logic signed [63:0]     dy;
  logic signed [39:0]     atan_v;
  logic [CCW-1:0]         ccnt;
  logic signed [39:0]     qz;
  logic [23:0]            mag_q;
  logic                   msat;
  logic                   res_valid;

  assign empty     = !res_valid;
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign mul_start = q_pop || ((state == B_COS) && mul_done);
  assign mul_a     = (state == B_IDLE) ? q_data.a2 : a2;
  assign mul_c     = (state == B_IDLE) ? cos_w0 : sin_w0;
  assign re_r      = sat_sub(a1, mul_res);

  assign ure = re[63] ? 64'd0 - re : re;
  assign uim = im[63] ? 64'd0 - im : im;

  // partial products of the two squares
  assign sq_src   = k[2] ? uim : ure;
  assign sq_a     = k[1] ? sq_src[63:32] : sq_src[31:0];
  assign sq_b     = k[0] ? sq_src[63:32] : sq_src[31:0];
  assign sq_prod  = sq_a * sq_b;
  assign acc_next = pvalid ? acc + (128'(prod) << pshift) : acc;

  // one root bit a step
  assign rem_sh = {rem[65:0], val[127:126]};
  assign trial  = {2'b00, root, 2'b01};
  assign sq_ge  = rem_sh >= trial;

  assign n_low  = COUNT_WIDTH'(block_length);
  assign n_full = (n_low == '0) ? {1'b1, {COUNT_WIDTH{1'b0}}} : {1'b0, n_low};
  assign rsum   = {1'b0, root} + (65'(n_full) << 20);

  // one quotient bit a step
  assign dr2  = {drem[COUNT_WIDTH:0], dq[DIV_W-1]};
  assign d_ge = dr2 >= {1'b0, n_full};

  assign mx     = (nx > ny) ? nx : ny;
  assign dx     = y >>> ccnt;
  assign dy     = x >>> ccnt;
  assign atan_v = $signed({8'd0, atan_q30(5'(ccnt))});
  assign qz     = (z + 40'sd65536) >>> 17;

  gsb_mulq30 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .c     (mul_c),
    .done  (mul_done),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
      pvalid    <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            a1    <= q_data.a1;
            a2    <= q_data.a2;
            sat_f <= q_data.ovf;
            state <= B_COS;
          end
        end
        B_COS: begin
          if (mul_done) begin
            re    <= re_r.v;
            sat_f <= sat_f || mul_ovf || re_r.f;
            state <= B_SIN;
          end
        end
        B_SIN: begin
          if (mul_done) begin
            im     <= mul_res;
            sat_f  <= sat_f || mul_ovf;
            acc    <= '0;
            k      <= '0;
            pvalid <= 1'b0;
            state  <= B_SQ;
          end
        end
        B_SQ: begin
          acc <= acc_next;
          if (k == 4'd8) begin
            val    <= acc_next;
            rem    <= '0;
            root   <= '0;
            scnt   <= '0;
            pvalid <= 1'b0;
            state  <= B_SQRT;
          end else begin
            prod   <= sq_prod;
            pshift <= {k[1] & k[0], k[1] ^ k[0], 5'd0};
            pvalid <= 1'b1;
            k      <= k + 1'b1;
          end
        end
        B_SQRT: begin
          rem  <= sq_ge ? rem_sh - trial : rem_sh;
          root <= {root[62:0], sq_ge};
          val  <= {val[125:0], 2'b00};
          scnt <= scnt + 1'b1;
          if (scnt == 6'd63) begin
            state <= B_DIVLD;
          end
        end
        B_DIVLD: begin
          dq    <= rsum[64:21];
          drem  <= '0;
          dcnt  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          if (dcnt == 6'(DIV_W)) begin
            msat  <= dq > DIV_W'(24'hFFFFFF);
            mag_q <= (dq > DIV_W'(24'hFFFFFF)) ? 24'hFFFFFF : dq[23:0];
            nx    <= ure;
            ny    <= uim;
            if (ure == '0 && uim == '0) begin
              z     <= '0;
              state <= B_FIN;
            end else begin
              state <= B_NORM;
            end
          end else begin
            drem <= d_ge ? dr2 - {1'b0, n_full} : dr2;
            dq   <= {dq[DIV_W-2:0], d_ge};
            dcnt <= dcnt + 1'b1;
          end
        end
        B_NORM: begin
          if (mx[63:60] != 4'd0) begin
            nx <= nx >> 1;
            ny <= ny >> 1;
          end else if (!mx[59]) begin
            nx <= nx << 1;
            ny <= ny << 1;
          end else begin
            x    <= nx;
            y    <= (re[63] != im[63]) ? 64'd0 - ny : ny;
            z    <= re[63] ? (im[63] ? -PI_Q30 : PI_Q30) : 40'sd0;
            ccnt <= '0;
            state <= B_ROT;
          end
        end
        B_ROT: begin
          if (ccnt == CCW'(CORDIC_STEPS)) begin
            state <= B_FIN;
          end else begin
            if (y > 64'sd0) begin
              x <= x + dx;
              y <= y - dy;
              z <= z + atan_v;
            end else begin
              x <= x - dx;
              y <= y + dy;
              z <= z - atan_v;
            end
            ccnt <= ccnt + 1'b1;
          end
        end
        B_FIN: begin
          if (!res_valid) begin
            real_part <= re;
            imag_part <= im;
            magnitude <= mag_q;
            saturated <= sat_f || msat;
            if (qz > 40'sd25736) begin
              phase <= 16'sd25736;
            end else if (qz < -40'sd25736) begin
              phase <= -16'sd25736;
            end else begin
              phase <= qz[15:0];
            end
            res_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/goertzel_single_bin_dft_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// goertzel_single_bin_dft_top
// Single-bin Goertzel DFT with amplitude and phase of each window.
// ----------------------------------------------------------------------------
// For each sample the recurrence product goes through one 32x32 multiplier
// in two halves, then a rounding step, a saturating add and a saturating
// subtract; no new sample is taken before that is done. After the last
// sample of a window the state is queued (two windows deep) and the finish
// unit works through each window: two coefficient products, eight square
// partial products, a 64-step square root, a 44-step divide, a normalize
// shift and one CORDIC rotation per cycle. Short windows stall the sample
// side once both queue slots hold unfinished windows.
module goertzel_single_bin_dft_top #(
  parameter int SAMPLE_WIDTH = gsb_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = gsb_pkg::COUNT_WIDTH_DEF,
  parameter int CORDIC_STEPS = gsb_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [SAMPLE_WIDTH-1:0]         sample,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [63:0]              real_part,
  output logic signed [63:0]              imag_part,
  output logic [23:0]                     magnitude,
  output logic signed [15:0]              phase,
  output logic                            saturated,
  input  logic                            wr_en,
  input  logic [gsb_pkg::REG_INDEX_W-1:0] wr_index,
  input  logic [31:0]                     wr_data
);
  import gsb_pkg::*;

  logic signed [31:0] two_cos_w0;
  logic signed [31:0] cos_w0;
  logic signed [31:0] sin_w0;
  logic [15:0]        block_length;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  entry_t             q_in;
  entry_t             q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_cos_w0   <= TWO_COS_RESET;
      cos_w0       <= COS_RESET;
      sin_w0       <= SIN_RESET;
      block_length <= LENGTH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TWO_COS_W0:   two_cos_w0   <= wr_data;
        REG_COS_W0:       cos_w0       <= wr_data;
        REG_SIN_W0:       sin_w0       <= wr_data;
        REG_BLOCK_LENGTH: block_length <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  gsb_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .sample       (sample),
    .full         (full),
    .two_cos_w0   (two_cos_w0),
    .block_length (block_length),
    .q_push       (q_push),
    .q_data       (q_in),
    .q_full       (q_full)
  );

  gsb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_in),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_data (q_out),
    .q_empty (q_empty)
  );

  gsb_back #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_out),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .cos_w0       (cos_w0),
    .sin_w0       (sin_w0),
    .block_length (block_length),
    .pop          (pop),
    .empty        (empty),
    .real_part    (real_part),
    .imag_part    (imag_part),
    .magnitude    (magnitude),
    .phase        (phase),
    .saturated    (saturated)
  );

endmodule
`default_nettype wire

// ----- rtl/gsb_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsb_checker
// Port-level checks of the Goertzel bin engine, bound to the top level.
// ----------------------------------------------------------------------------
module gsb_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [63:0] real_part,
  input logic [23:0]        magnitude,
  input logic signed [15:0] phase
);

  // idle queues after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not idle after reset");

  // a waiting result is not dropped
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

  // a waiting result does not change
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(real_part) && $stable(magnitude) && $stable(phase)))
    else $error("result changed while waiting");

  // phase within plus or minus pi
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (phase <= 16'sd25736 && phase >= -16'sd25736))
    else $error("phase out of range");

endmodule

bind goertzel_single_bin_dft_top gsb_checker u_checker (.*);
`default_nettype wire
